[rtl/pfa_pkg.sv]
// Shared types and constants of the partition fit allocator.
// No dependencies; the files that use it refer to it by scoped names.
package pfa_pkg;

    localparam int NUM_PARTS_DEF = 8;
    localparam int SIZE_BITS_DEF = 16;

    localparam int PART_W     = 3;
    localparam int SIZE_W     = 16;
    localparam int TOTAL_W    = 19;
    localparam int COUNT_W    = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX   = 19'h7FFFF;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = 2'd1;

    // opcodes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_ALLOC = 1'b1;

    typedef enum logic [1:0] {
        POL_FIRST = 2'd0,
        POL_BEST  = 2'd1,
        POL_NEXT  = 2'd2,
        POL_WORST = 2'd3
    } pfa_policy_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCAN,
        ST_DRAIN,
        ST_POST
    } pfa_state_t;

    typedef struct packed {
        logic              op;
        logic [PART_W-1:0] part_index;
        logic [SIZE_W-1:0] size_value;
    } pfa_in_t;

    typedef struct packed {
        logic               granted;
        logic [PART_W-1:0]  chosen_part;
        logic [SIZE_W-1:0]  left_in_part;
        logic [TOTAL_W-1:0] total_free;
    } pfa_out_t;

    // sequencer to evaluation unit
    typedef struct packed {
        logic        clear;   // start of a new item
        logic        step;    // one entry's data is present this cycle
        logic        select;  // item is an allocation, candidates are tracked
        pfa_policy_t policy;
    } pfa_eval_ctl_t;

endpackage

[rtl/partition_fit_allocator.sv]
// Top level of the partition fit allocator: sequencer, config registers,
// partition table and busy marks. Depends on pfa_pkg, pfa_ram, pfa_eval.
//
// Usage:
//   Command channel: an item (cmd) is taken at a clock edge with start high
//   and busy low. op = load writes part_index's size and clears its busy
//   mark; op = allocate places a job of size_value by the current policy.
//   Every item returns exactly one result beat: result is valid while done
//   is high, for one cycle only. The receiver cannot stall; done lands in
//   the cycle busy drops, so the next item may start in that same cycle.
//   Steps: an allocate goes through scan, drain and post; a load first
//   writes the table and then does the same. The scan covers cnt entries,
//   where cnt is the number of partitions in use (min of partition_count
//   and NUM_PARTS). With cnt zero the scan and drain are skipped.
//   Throughput: the block takes no new item while busy, so items do not
//   overlap. The scan loop reads and evaluates one table entry per cycle
//   through the single-port table read and the shared fit unit, then come
//   the drain state and the update/result state.
//   Config channel: cfg_ready is always high; writes are meant for idle.
//   Reset: all partition sizes read as zero (per-entry valid bits), busy
//   marks and rover cleared, policy first fit, partition_count 8. No
//   clearing pass is needed, so the block is ready right after reset.
module partition_fit_allocator #(
    parameter int NUM_PARTS = pfa_pkg::NUM_PARTS_DEF,
    parameter int SIZE_BITS = pfa_pkg::SIZE_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  pfa_pkg::pfa_in_t               cmd,
    output logic                           done,
    output pfa_pkg::pfa_out_t              result,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [pfa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pfa_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W = (NUM_PARTS > 1) ? $clog2(NUM_PARTS) : 1;
    localparam int CNT_W = $clog2(NUM_PARTS + 1);

    // ---------------- configuration registers ----------------
    pfa_pkg::pfa_policy_t           policy_reg;
    logic [pfa_pkg::COUNT_W-1:0]    count_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= pfa_pkg::POL_FIRST;
            count_reg  <= pfa_pkg::COUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                pfa_pkg::CFG_POLICY: policy_reg <= pfa_pkg::pfa_policy_t'(cfg_data[1:0]);
                pfa_pkg::CFG_COUNT:  count_reg  <= cfg_data[pfa_pkg::COUNT_W-1:0];
                default:             ;  // unknown index: dropped
            endcase
        end
    end

    // partitions in use, clipped to the table depth
    logic [CNT_W-1:0] cnt;
    assign cnt = (32'(count_reg) > NUM_PARTS) ? CNT_W'(NUM_PARTS) : CNT_W'(count_reg);

    // ---------------- item registers ----------------
    logic                       op_reg;
    logic [pfa_pkg::PART_W-1:0] idx_reg;
    logic [SIZE_BITS-1:0]       job_reg;
    logic                       accept;

    assign accept = start && !busy;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= cmd.op;
            idx_reg <= cmd.part_index;
            job_reg <= SIZE_BITS'(cmd.size_value);
        end
    end

    // ---------------- sequencer ----------------
    pfa_pkg::pfa_state_t state_reg, state_next;
    logic [IDX_W-1:0]    scan_ptr_reg, scan_ptr_next;
    logic                scan_last;

    assign scan_last = (CNT_W'(scan_ptr_reg) + CNT_W'(1)) == cnt;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pfa_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (cmd.op == pfa_pkg::OP_LOAD)
                    begin
                        state_next = pfa_pkg::ST_LOAD;
                    end
                    else if (cnt == '0)
                    begin
                        state_next = pfa_pkg::ST_POST;
                    end
                    else
                    begin
                        state_next = pfa_pkg::ST_SCAN;
                    end
                end
            end
            pfa_pkg::ST_LOAD:
            begin
                state_next = (cnt == '0) ? pfa_pkg::ST_POST : pfa_pkg::ST_SCAN;
            end
            pfa_pkg::ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = pfa_pkg::ST_DRAIN;
                end
            end
            pfa_pkg::ST_DRAIN: state_next = pfa_pkg::ST_POST;
            pfa_pkg::ST_POST:  state_next = pfa_pkg::ST_IDLE;
            default:           state_next = pfa_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        scan_ptr_next = '0;
        if (state_reg == pfa_pkg::ST_SCAN && !scan_last)
        begin
            scan_ptr_next = scan_ptr_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= pfa_pkg::ST_IDLE;
            scan_ptr_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_ptr_reg <= scan_ptr_next;
        end
    end

    // ---------------- evaluation unit hookup ----------------
    pfa_pkg::pfa_eval_ctl_t     eval_ctl;
    logic                       ev_found;
    logic [IDX_W-1:0]           ev_pick;
    logic [SIZE_BITS-1:0]       ev_left;
    logic [pfa_pkg::TOTAL_W-1:0] ev_total;

    // table pipeline: address in SCAN, data in the cycle after
    logic                 rd_vld_reg;
    logic [IDX_W-1:0]     rd_idx_reg;
    logic                 rd_valid_reg;
    logic                 rd_busy_reg;
    logic [SIZE_BITS-1:0] ram_q;
    logic [SIZE_BITS-1:0] entry_size;

    logic [NUM_PARTS-1:0] valid_reg;
    logic [NUM_PARTS-1:0] busy_mark_reg;
    logic [IDX_W-1:0]     rover_reg;
    logic [IDX_W-1:0]     start_idx;

    logic                 load_ok;
    logic                 grant;
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [SIZE_BITS-1:0] ram_wdata;

    assign entry_size = rd_valid_reg ? ram_q : '0;
    assign start_idx  = (CNT_W'(rover_reg) < cnt) ? rover_reg : '0;
    assign load_ok    = 32'(idx_reg) < NUM_PARTS;
    assign grant      = (state_reg == pfa_pkg::ST_POST) && ev_found;

    // control outputs of the sequencer
    always_comb
    begin
        busy            = state_reg != pfa_pkg::ST_IDLE;
        eval_ctl.clear  = accept;
        eval_ctl.step   = rd_vld_reg;
        eval_ctl.select = op_reg == pfa_pkg::OP_ALLOC;
        eval_ctl.policy = policy_reg;
        ram_we          = 1'b0;
        ram_waddr       = IDX_W'(idx_reg);
        ram_wdata       = job_reg;
        if (state_reg == pfa_pkg::ST_LOAD && load_ok)
        begin
            ram_we = 1'b1;
        end
        else if (grant)
        begin
            ram_we    = 1'b1;
            ram_waddr = ev_pick;
            ram_wdata = ev_left;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= state_reg == pfa_pkg::ST_SCAN;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg   <= scan_ptr_reg;
        rd_valid_reg <= valid_reg[scan_ptr_reg];
        rd_busy_reg  <= busy_mark_reg[scan_ptr_reg];
    end

    // valid bits stand in for the all-zero reset of the size table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            busy_mark_reg <= '0;
            rover_reg     <= '0;
        end
        else
        begin
            if (ram_we)
            begin
                valid_reg[ram_waddr] <= 1'b1;
            end
            if (state_reg == pfa_pkg::ST_LOAD && load_ok)
            begin
                busy_mark_reg[ram_waddr] <= 1'b0;
            end
            if (grant)
            begin
                busy_mark_reg[ev_pick] <= 1'b1;
                if (policy_reg == pfa_pkg::POL_NEXT)
                begin
                    rover_reg <= ((CNT_W'(ev_pick) + CNT_W'(1)) >= cnt)
                                 ? '0 : ev_pick + IDX_W'(1);
                end
            end
        end
    end

    pfa_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (NUM_PARTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (scan_ptr_reg),
        .rdata (ram_q)
    );

    pfa_eval #(
        .NUM_PARTS (NUM_PARTS),
        .SIZE_BITS (SIZE_BITS)
    ) u_eval (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (eval_ctl),
        .entry_idx  (rd_idx_reg),
        .entry_size (entry_size),
        .entry_busy (rd_busy_reg),
        .start_idx  (start_idx),
        .job        (job_reg),
        .found      (ev_found),
        .pick       (ev_pick),
        .pick_left  (ev_left),
        .total_free (ev_total)
    );

    // ---------------- result beat ----------------
    logic              done_reg;
    pfa_pkg::pfa_out_t result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= state_reg == pfa_pkg::ST_POST;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == pfa_pkg::ST_POST)
        begin
            result_reg.granted      <= ev_found;
            result_reg.chosen_part  <= ev_found ? pfa_pkg::PART_W'(ev_pick) : '0;
            result_reg.left_in_part <= ev_found ? pfa_pkg::SIZE_W'(ev_left) : '0;
            result_reg.total_free   <= ev_total;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    // ---------------- assertions ----------------
    // the result beat comes exactly as the sequencer goes back to idle
    a_done_on_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result beat");

    // every item passes through POST before its beat, so beats never abut
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result beat held longer than one cycle");

    // a grant always names a partition that is in use
    a_grant_in_use: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.granted && (32'(cnt) <= 8))
        |-> (32'(result.chosen_part) < 32'(cnt)))
        else $error("grant to a partition outside the count in use");

endmodule

[rtl/pfa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pfa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/pfa_eval.sv]
// Per-entry fit evaluation: one subtract/compare unit reused for every
// scanned entry, plus the candidate and running-sum registers.
// Depends on pfa_pkg.
module pfa_eval #(
    parameter int NUM_PARTS = pfa_pkg::NUM_PARTS_DEF,
    parameter int SIZE_BITS = pfa_pkg::SIZE_BITS_DEF,
    localparam int IDX_W    = (NUM_PARTS > 1) ? $clog2(NUM_PARTS) : 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  pfa_pkg::pfa_eval_ctl_t      ctl,
    input  logic [IDX_W-1:0]            entry_idx,
    input  logic [SIZE_BITS-1:0]        entry_size,
    input  logic                        entry_busy,
    input  logic [IDX_W-1:0]            start_idx,
    input  logic [SIZE_BITS-1:0]        job,
    output logic                        found,
    output logic [IDX_W-1:0]            pick,
    output logic [SIZE_BITS-1:0]        pick_left,
    output logic [pfa_pkg::TOTAL_W-1:0] total_free
);

    localparam int SUM_W = SIZE_BITS + IDX_W;
    localparam int EXT_W = (SUM_W > pfa_pkg::TOTAL_W) ? SUM_W : pfa_pkg::TOTAL_W;

    logic                 found_reg, found_next;
    logic                 found_hi_reg, found_hi_next;
    logic [IDX_W-1:0]     pick_reg, pick_next;
    logic [SIZE_BITS-1:0] left_reg, left_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;

    logic                 fits, elig, hi, take;
    logic [SIZE_BITS-1:0] left;
    logic [SUM_W-1:0]     sum_fin;
    logic [EXT_W-1:0]     sum_ext;

    always_comb
    begin
        fits = entry_size >= job;
        left = entry_size - job;
        hi   = (ctl.policy == pfa_pkg::POL_FIRST) || (entry_idx >= start_idx);
        elig = fits;
        take = 1'b0;
        case (ctl.policy) inside
            pfa_pkg::POL_FIRST, pfa_pkg::POL_NEXT:
            begin
                // an entry at or after the start pointer supersedes a wrapped one
                elig = fits && !entry_busy;
                take = elig && (!found_reg || (hi && !found_hi_reg));
            end
            pfa_pkg::POL_BEST:
            begin
                take = elig && (!found_reg || (left < left_reg));
            end
            default:
            begin
                take = elig && (!found_reg || (left > left_reg));
            end
        endcase
        take = take && ctl.select;
    end

    always_comb
    begin
        found_next    = found_reg;
        found_hi_next = found_hi_reg;
        pick_next     = pick_reg;
        left_next     = left_reg;
        sum_next      = sum_reg;
        if (ctl.clear)
        begin
            found_next    = 1'b0;
            found_hi_next = 1'b0;
            sum_next      = '0;
        end
        else if (ctl.step)
        begin
            sum_next = sum_reg + SUM_W'(entry_size);
            if (take)
            begin
                found_next    = 1'b1;
                found_hi_next = hi;
                pick_next     = entry_idx;
                left_next     = left;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg    <= 1'b0;
            found_hi_reg <= 1'b0;
            sum_reg      <= '0;
        end
        else
        begin
            found_reg    <= found_next;
            found_hi_reg <= found_hi_next;
            sum_reg      <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pick_reg <= pick_next;
        left_reg <= left_next;
    end

    // free space after the grant is taken out, saturated to the field width
    always_comb
    begin
        sum_fin = found_reg ? (sum_reg - SUM_W'(job)) : sum_reg;
        sum_ext = EXT_W'(sum_fin);
        if (sum_ext > EXT_W'(pfa_pkg::TOTAL_MAX))
        begin
            total_free = pfa_pkg::TOTAL_MAX;
        end
        else
        begin
            total_free = pfa_pkg::TOTAL_W'(sum_ext);
        end
    end

    assign found     = found_reg;
    assign pick      = pick_reg;
    assign pick_left = left_reg;

endmodule

[sim/partition_fit_allocator_test.sv]
// Self-checking testbench for partition_fit_allocator: directed table, then random phases.
// Depends on pfa_pkg and the partition_fit_allocator RTL only; reads no files.
`timescale 1ns / 100ps

module partition_fit_allocator_test;

    // register indexes the block does not implement; writes must be no-ops
    localparam logic [pfa_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [pfa_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef enum logic {
        ROW_JOB,
        ROW_REG
    } row_kind_t;

    // one directed stimulus row: either a command beat or a register write
    typedef struct packed {
        row_kind_t                      kind;
        pfa_pkg::pfa_in_t               job;
        logic [pfa_pkg::CFG_IDX_W-1:0]  reg_idx;
        logic [pfa_pkg::CFG_DATA_W-1:0] reg_data;
        logic                           typed;     // want holds a hand-written result
        pfa_pkg::pfa_out_t              want;
    } stim_row_t;

    logic                           clk;
    logic                           rst_n;
    logic                           start;
    logic                           busy;
    pfa_pkg::pfa_in_t               cmd;
    logic                           done;
    pfa_pkg::pfa_out_t              result;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [pfa_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [pfa_pkg::CFG_DATA_W-1:0] cfg_data;

    // shadow copy of the partition table and config, advanced per accepted beat
    logic [pfa_pkg::SIZE_W-1:0]  part_left [pfa_pkg::NUM_PARTS_DEF];
    bit                          part_taken [pfa_pkg::NUM_PARTS_DEF];
    logic [pfa_pkg::PART_W-1:0]  rover_q;
    pfa_pkg::pfa_policy_t        policy_q;
    logic [pfa_pkg::COUNT_W-1:0] count_q;

    pfa_pkg::pfa_out_t pending_results [$];   // results owed by the block, oldest first
    stim_row_t         directed_rows [$];
    pfa_pkg::pfa_out_t due;
    int                fail_count = 0;
    int                idle_pct = 0;          // chance per beat that the sender leaves a gap

    partition_fit_allocator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Predict the result of one command and update the shadow table.
    // total_free is summed after the update, over the partitions in use only.
    function automatic pfa_pkg::pfa_out_t fit_outcome(pfa_pkg::pfa_in_t job);
        int                         n;
        int                         pick;
        int                         p;
        int                         sum;
        logic [pfa_pkg::SIZE_W-1:0] slack;
        logic [pfa_pkg::SIZE_W-1:0] best_slack;
        pfa_pkg::pfa_out_t          res;
        n = (count_q > pfa_pkg::NUM_PARTS_DEF) ? pfa_pkg::NUM_PARTS_DEF : int'(count_q);
        pick = -1;
        best_slack = '0;
        res = '0;
        if (job.op == pfa_pkg::OP_LOAD)
        begin
            part_left[job.part_index] = job.size_value;
            part_taken[job.part_index] = 1'b0;
        end
        else
        begin
            case (policy_q)
                pfa_pkg::POL_FIRST:
                begin
                    for (int i = 0; i < n; i++)
                        if (pick < 0 && !part_taken[i] && part_left[i] >= job.size_value)
                            pick = i;
                end
                pfa_pkg::POL_NEXT:
                begin
                    // a rover beyond the active count restarts the scan at entry 0
                    p = (rover_q < n) ? int'(rover_q) : 0;
                    for (int i = 0; i < n; i++)
                    begin
                        if (pick < 0 && !part_taken[p] && part_left[p] >= job.size_value)
                            pick = p;
                        p = (p + 1 >= n) ? 0 : p + 1;
                    end
                end
                default:
                begin
                    // best / worst: busy marks ignored, strict compare keeps lowest index
                    for (int i = 0; i < n; i++)
                    begin
                        if (part_left[i] >= job.size_value)
                        begin
                            slack = part_left[i] - job.size_value;
                            if (pick < 0 || (policy_q == pfa_pkg::POL_BEST
                                             ? slack < best_slack
                                             : slack > best_slack))
                            begin
                                best_slack = slack;
                                pick = i;
                            end
                        end
                    end
                end
            endcase
            if (pick >= 0)
            begin
                part_left[pick] = part_left[pick] - job.size_value;
                part_taken[pick] = 1'b1;
                if (policy_q == pfa_pkg::POL_NEXT)
                    rover_q = (pick + 1 >= n) ? '0 : pfa_pkg::PART_W'(pick + 1);
                res.granted = 1'b1;
                res.chosen_part = pick[pfa_pkg::PART_W-1:0];
                res.left_in_part = part_left[pick];
            end
        end
        sum = 0;
        for (int i = 0; i < n; i++)
            sum += part_left[i];
        res.total_free = (sum > pfa_pkg::TOTAL_MAX) ? pfa_pkg::TOTAL_MAX
                                                    : sum[pfa_pkg::TOTAL_W-1:0];
        return res;
    endfunction

    // only the low bits that each register holds are kept; other indexes are dropped
    function automatic void apply_reg_write(logic [pfa_pkg::CFG_IDX_W-1:0] idx,
                                            logic [pfa_pkg::CFG_DATA_W-1:0] val);
        case (idx)
            pfa_pkg::CFG_POLICY: policy_q = pfa_pkg::pfa_policy_t'(val[1:0]);
            pfa_pkg::CFG_COUNT:  count_q = val[pfa_pkg::COUNT_W-1:0];
            default: ;
        endcase
    endfunction

    // Random command: loads refill partitions so allocations keep finding room.
    // Allocation sizes span many magnitudes so both grants and misses occur.
    function automatic pfa_pkg::pfa_in_t random_job();
        pfa_pkg::pfa_in_t job;
        int               n;
        int               w;
        int               r;
        n = (count_q > pfa_pkg::NUM_PARTS_DEF) ? pfa_pkg::NUM_PARTS_DEF : int'(count_q);
        job.op = ($urandom_range(0, 99) < 40) ? pfa_pkg::OP_LOAD : pfa_pkg::OP_ALLOC;
        if (n > 0 && $urandom_range(0, 99) < 80)
            job.part_index = pfa_pkg::PART_W'($urandom_range(0, n - 1));
        else
            job.part_index = pfa_pkg::PART_W'($urandom_range(0, 7));
        r = $urandom_range(0, 99);
        if (r < 5)
            job.size_value = '0;
        else if (r < 10)
            job.size_value = '1;
        else
        begin
            w = (job.op == pfa_pkg::OP_LOAD) ? $urandom_range(8, 16) : $urandom_range(1, 16);
            job.size_value = pfa_pkg::SIZE_W'($urandom & ((32'd1 << w) - 1));
        end
        return job;
    endfunction

    task automatic put_item(logic o, logic [pfa_pkg::PART_W-1:0] idx,
                            logic [pfa_pkg::SIZE_W-1:0] sz);
        stim_row_t row;
        row = '0;
        row.kind = ROW_JOB;
        row.job = '{op: o, part_index: idx, size_value: sz};
        directed_rows.push_back(row);
    endtask

    task automatic put_known(logic o, logic [pfa_pkg::PART_W-1:0] idx,
                             logic [pfa_pkg::SIZE_W-1:0] sz,
                             logic g, logic [pfa_pkg::PART_W-1:0] part,
                             logic [pfa_pkg::SIZE_W-1:0] left,
                             logic [pfa_pkg::TOTAL_W-1:0] total);
        stim_row_t row;
        row = '0;
        row.kind = ROW_JOB;
        row.job = '{op: o, part_index: idx, size_value: sz};
        row.typed = 1'b1;
        row.want = '{granted: g, chosen_part: part, left_in_part: left, total_free: total};
        directed_rows.push_back(row);
    endtask

    task automatic put_reg(logic [pfa_pkg::CFG_IDX_W-1:0] idx,
                           logic [pfa_pkg::CFG_DATA_W-1:0] val);
        stim_row_t row;
        row = '0;
        row.kind = ROW_REG;
        row.reg_idx = idx;
        row.reg_data = val;
        directed_rows.push_back(row);
    endtask

    // Offer one command beat, optionally after a random gap. start stays high
    // from one beat to the next when there is no gap, so back-to-back works.
    task automatic send_job(pfa_pkg::pfa_in_t job, logic typed, pfa_pkg::pfa_out_t want);
        int                gap;
        pfa_pkg::pfa_out_t predicted;
        gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 3) : 0;
        repeat (gap)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start <= 1'b1;
        cmd <= job;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predicted = fit_outcome(job);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // Every command returns a result, so an empty queue means the block is idle.
    task automatic wait_idle();
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (2)
            @(negedge clk);
    endtask

    task automatic write_reg(logic [pfa_pkg::CFG_IDX_W-1:0] idx,
                             logic [pfa_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        apply_reg_write(idx, val);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Result monitor: the receiver cannot stall, so every done beat is taken.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result beat with no outstanding command");
                fail_count++;
            end
            else
            begin
                due = pending_results.pop_front();
                if (result.granted !== due.granted)
                begin
                    $error("granted: expected %0d, got %0d", due.granted, result.granted);
                    fail_count++;
                end
                if (result.chosen_part !== due.chosen_part)
                begin
                    $error("chosen_part: expected %0d, got %0d",
                           due.chosen_part, result.chosen_part);
                    fail_count++;
                end
                if (result.left_in_part !== due.left_in_part)
                begin
                    $error("left_in_part: expected %0d, got %0d",
                           due.left_in_part, result.left_in_part);
                    fail_count++;
                end
                if (result.total_free !== due.total_free)
                begin
                    $error("total_free: expected %0d, got %0d",
                           due.total_free, result.total_free);
                    fail_count++;
                end
            end
        end
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #1_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        int                             n_items;
        logic [pfa_pkg::CFG_DATA_W-1:0] d;
        int                             phase_counts [12];
        int                             idle_modes [3];

        phase_counts = '{8, 1, 0, 15, 5, 8, 3, 8, 2, 0, 7, 6};
        idle_modes = '{0, 53, 22};
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        for (int i = 0; i < pfa_pkg::NUM_PARTS_DEF; i++)
        begin
            part_left[i] = '0;
            part_taken[i] = 1'b0;
        end
        rover_q = '0;
        policy_q = pfa_pkg::POL_FIRST;
        count_q = pfa_pkg::COUNT_RESET;

        // Directed table. Typed results are the ones obvious by inspection:
        // the empty table after reset, full-size loads and the zero count.
        // zero job, empty table
        put_known(pfa_pkg::OP_ALLOC, 3'd5, 16'd0, 1'b1, 3'd0, 16'd0, 19'd0);
        // nothing fits
        put_known(pfa_pkg::OP_ALLOC, 3'd0, 16'd1, 1'b0, 3'd0, 16'd0, 19'd0);
        put_known(pfa_pkg::OP_LOAD, 3'd0, 16'hFFFF, 1'b0, 3'd0, 16'd0, 19'd65535);
        put_known(pfa_pkg::OP_LOAD, 3'd7, 16'hFFFF, 1'b0, 3'd0, 16'd0, 19'd131070);
        put_item(pfa_pkg::OP_LOAD, 3'd3, 16'h5555);
        put_item(pfa_pkg::OP_LOAD, 3'd4, 16'hAAAA);
        put_item(pfa_pkg::OP_ALLOC, 3'd2, 16'h5000);
        put_item(pfa_pkg::OP_ALLOC, 3'd7, 16'hFFFF);               // max job, skips busy 0
        put_reg(pfa_pkg::CFG_POLICY, {6'd0, pfa_pkg::POL_BEST});
        put_item(pfa_pkg::OP_LOAD, 3'd1, 16'd100);
        put_item(pfa_pkg::OP_LOAD, 3'd2, 16'd90);
        put_item(pfa_pkg::OP_ALLOC, 3'd0, 16'd80);
        put_item(pfa_pkg::OP_ALLOC, 3'd0, 16'd80);
        put_reg(pfa_pkg::CFG_POLICY, {6'd0, pfa_pkg::POL_NEXT});
        put_item(pfa_pkg::OP_ALLOC, 3'd1, 16'd5);
        put_item(pfa_pkg::OP_ALLOC, 3'd6, 16'd5);
        put_item(pfa_pkg::OP_ALLOC, 3'd6, 16'd1);                  // full wrap, no grant
        put_reg(pfa_pkg::CFG_COUNT, 8'hF5);                        // rover now past count
        put_item(pfa_pkg::OP_LOAD, 3'd6, 16'd1000);                // stored, not counted
        put_item(pfa_pkg::OP_LOAD, 3'd0, 16'd300);
        put_item(pfa_pkg::OP_ALLOC, 3'd0, 16'd200);
        put_reg(pfa_pkg::CFG_POLICY, 8'hFF);                       // worst fit, upper bits set
        put_item(pfa_pkg::OP_ALLOC, 3'd0, 16'd10);
        put_item(pfa_pkg::OP_ALLOC, 3'd0, 16'hFFFF);
        put_reg(pfa_pkg::CFG_COUNT, 8'h00);                        // no partitions in use
        put_known(pfa_pkg::OP_ALLOC, 3'd0, 16'd0, 1'b0, 3'd0, 16'd0, 19'd0);
        put_known(pfa_pkg::OP_LOAD, 3'd5, 16'd1234, 1'b0, 3'd0, 16'd0, 19'd0);
        put_reg(pfa_pkg::CFG_COUNT, 8'h0F);                        // clamps to eight
        put_item(pfa_pkg::OP_ALLOC, 3'd3, 16'd0);
        put_reg(CFG_SPARE_A, 8'hA5);
        put_reg(CFG_SPARE_B, 8'h5A);
        put_reg(pfa_pkg::CFG_POLICY, {6'd0, pfa_pkg::POL_FIRST});
        put_item(pfa_pkg::OP_LOAD, 3'd7, 16'd0);
        put_item(pfa_pkg::OP_ALLOC, 3'd7, 16'd0);

        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        idle_pct = 22;
        foreach (directed_rows[k])
        begin
            if (directed_rows[k].kind == ROW_REG)
            begin
                wait_idle();
                write_reg(directed_rows[k].reg_idx, directed_rows[k].reg_data);
            end
            else
                send_job(directed_rows[k].job, directed_rows[k].typed, directed_rows[k].want);
        end

        // Random phases: policy walks all four, count hits its extremes,
        // idle mode rotates so phases run with and without gaps between items.
        for (int ph = 0; ph < 12; ph++)
        begin
            wait_idle();
            idle_pct = idle_modes[ph % 3];
            d = pfa_pkg::CFG_DATA_W'($urandom);
            d[1:0] = 2'(ph % 4);
            write_reg(pfa_pkg::CFG_POLICY, d);
            d = pfa_pkg::CFG_DATA_W'($urandom);
            d[pfa_pkg::COUNT_W-1:0] = pfa_pkg::COUNT_W'(phase_counts[ph]);
            write_reg(pfa_pkg::CFG_COUNT, d);
            if (ph % 6 == 1)
                write_reg(CFG_SPARE_A, pfa_pkg::CFG_DATA_W'($urandom));
            if (ph % 6 == 4)
                write_reg(CFG_SPARE_B, pfa_pkg::CFG_DATA_W'($urandom));
            n_items = (phase_counts[ph] == 0) ? 25 : 157;
            for (int j = 0; j < n_items; j++)
            begin
                // sender holds off mid-phase until every result is back
                if (j == n_items / 2)
                    wait_idle();
                send_job(random_job(), 1'b0, '0);
            end
        end

        wait_idle();
        repeat (12)
            @(posedge clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[partition_fit_allocator.f]
rtl/pfa_pkg.sv
rtl/pfa_ram.sv
rtl/pfa_eval.sv
rtl/partition_fit_allocator.sv
sim/partition_fit_allocator_test.sv
